/* hw/rtl/arpc_pkg.sv */
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the arp cache and responder
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned EntriesDflt = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 48;

  localparam logic [10:0] ArpMinLen = 11'd28;
  localparam logic [15:0] OpRequest = 16'd1;
  localparam logic [47:0] BcastMac  = {6{8'hFF}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_IP  = 2'd0,
    REG_OWN_MAC = 2'd1,
    REG_LINK_EN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] ip;
    logic [47:0] snd_mac;
    logic [31:0] tgt_ip;
    logic [15:0] arp_opcode;
    logic [10:0] packet_length;
  } in_beat_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] found_mac;
    logic        send_arp;
    logic        send_is_reply;
    logic [47:0] tx_dest_mac;
    logic [31:0] tx_target_ip;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

endpackage

/* hw/rtl/arpc_in_if.sv */
// ----------------------------------------------------------------------------
// arpc_in_if
// input channel: lookup or received arp packet beats
// ----------------------------------------------------------------------------
interface arpc_in_if;
  logic               valid;
  logic               ready;
  arpc_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/arpc_out_if.sv */
// ----------------------------------------------------------------------------
// arpc_out_if
// output channel: one result beat per input beat
// ----------------------------------------------------------------------------
interface arpc_out_if;
  logic                valid;
  logic                ready;
  arpc_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/arpc_table.sv */
// ----------------------------------------------------------------------------
// arpc_table
// binding store: ip/mac memory with registered read, valid bits in flops
// ----------------------------------------------------------------------------
module arpc_table #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::EntriesDflt,
  localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IdxW-1:0]      rd_addr_i,
  output arpc_pkg::entry_t     rd_entry_o,
  output logic                 rd_valid_o,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_addr_i,
  input  arpc_pkg::entry_t     wr_entry_i
);

  arpc_pkg::entry_t         mem_q [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_q;
  arpc_pkg::entry_t         rd_entry_q;
  logic                     rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_addr_i];
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_valid_o = rd_valid_q;

endmodule

/* hw/rtl/arp_cache_and_responder_unit.sv */
// ----------------------------------------------------------------------------
// arp_cache_and_responder_unit
// ipv4-to-mac cache with lookup, learning and arp reply/request decisions
// ----------------------------------------------------------------------------
// each beat is scanned against the table one entry per cycle, each registered
//   read compared with it, then a learned binding is written back in the
//   finish step; a new beat is taken only in the idle state
// the result register lets the next beat start while a result waits
// reset clears all valid bits and the config registers at once, no sweep
// ----------------------------------------------------------------------------
module arp_cache_and_responder_unit #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::EntriesDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [arpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [arpc_pkg::CfgDataW-1:0] cfg_wdata_i,
  arpc_in_if.sink                       req_i,
  arpc_out_if.source                    rsp_o
);

  localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(CACHE_ENTRIES - 1);
  localparam logic [CntW-1:0] EntryCnt = CntW'(CACHE_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [31:0] own_ip_q;
  logic        link_en_q;

  arpc_pkg::in_beat_t  item_q;
  logic [CntW-1:0]     scan_q, scan_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  logic                hit_q, hit_d;
  logic [IdxW-1:0]     hit_idx_q, hit_idx_d;
  logic [47:0]         hit_mac_q, hit_mac_d;
  logic                empty_q, empty_d;
  logic [IdxW-1:0]     empty_idx_q, empty_idx_d;

  arpc_pkg::out_beat_t out_q, out_d;
  logic                out_valid_q;

  logic                rd_en;
  arpc_pkg::entry_t    rd_entry;
  logic                rd_valid;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  arpc_pkg::entry_t    wr_entry;

  logic req_fire;
  logic out_load;
  logic learn;
  logic reply_ok;
  logic match;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      link_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (arpc_pkg::cfg_reg_e'(cfg_idx_i))
        arpc_pkg::REG_OWN_IP:  own_ip_q  <= cfg_wdata_i[31:0];
        arpc_pkg::REG_OWN_MAC: ; // used by frame building outside
        arpc_pkg::REG_LINK_EN: link_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || rsp_o.ready);

  assign rd_en = (state_q == ST_SCAN) && (scan_q < EntryCnt);
  assign match = cmp_vld_q && rd_valid && (rd_entry.ip == item_q.ip);

  arpc_table #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (scan_q[IdxW-1:0]),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry)
  );

  // scan sequencer
  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_mac_d   = hit_mac_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_SCAN;
          scan_d  = '0;
          hit_d   = 1'b0;
          empty_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          scan_d    = scan_q + CntW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[IdxW-1:0];
        end
        if (match && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          hit_mac_d = rd_entry.mac;
        end
        if (cmp_vld_q && !rd_valid && !empty_q) begin
          empty_d     = 1'b1;
          empty_idx_d = cmp_idx_q;
        end
        if (cmp_vld_q && (cmp_idx_q == LastIdx)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result and write-back
  assign learn    = item_q.kind && (item_q.packet_length >= arpc_pkg::ArpMinLen);
  assign reply_ok = learn && (item_q.arp_opcode == arpc_pkg::OpRequest) &&
                    (item_q.tgt_ip == own_ip_q) && link_en_q;

  assign wr_en        = out_load && learn;
  assign wr_addr      = hit_q ? hit_idx_q : (empty_q ? empty_idx_q : '0);
  assign wr_entry.ip  = item_q.ip;
  assign wr_entry.mac = item_q.snd_mac;

  always_comb begin
    out_d = '0;
    if (!item_q.kind) begin
      if (hit_q) begin
        out_d.hit       = 1'b1;
        out_d.found_mac = hit_mac_q;
      end else if (link_en_q) begin
        out_d.send_arp     = 1'b1;
        out_d.tx_dest_mac  = arpc_pkg::BcastMac;
        out_d.tx_target_ip = item_q.ip;
      end
    end else if (reply_ok) begin
      out_d.send_arp      = 1'b1;
      out_d.send_is_reply = 1'b1;
      out_d.tx_dest_mac   = item_q.snd_mac;
      out_d.tx_target_ip  = item_q.ip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      item_q <= req_i.data;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    cmp_idx_q   <= cmp_idx_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    hit_mac_q   <= hit_mac_d;
    empty_q     <= empty_d;
    empty_idx_q <= empty_idx_d;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // assertions
  a_rsp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the finish step");

  a_wr_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_FIN))
    else $error("table written outside the finish step");

  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == ST_SCAN))
    else $error("compare beat outside the scan");

  a_hit_xor_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.hit && out_q.send_arp))
    else $error("hit and transmit asserted together");

endmodule
